>>> design/hht_pkg.sv
// Shared types and constants for the hue histogram top-two block.
package hht_pkg;

  // Number of hue steps in the input hue scale (half degrees).
  localparam int HUE_SPAN = 180;

  // Width of a bin code in the result fields.
  localparam int BIN_FIELD_W = 5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GREY_HUE    = 2'd0;
  localparam logic [1:0] REG_BLACK_VALUE = 2'd1;
  localparam logic [1:0] REG_WHITE_VALUE = 2'd2;

  // Register reset values.
  localparam logic [7:0] GREY_HUE_RESET    = 8'd2;
  localparam logic [7:0] BLACK_VALUE_RESET = 8'd50;
  localparam logic [7:0] WHITE_VALUE_RESET = 8'd200;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] brightness;
    logic       inside_region;
    logic       last_pixel;
  } in_t;

  typedef struct packed {
    logic [BIN_FIELD_W-1:0] primary_bin;
    logic [BIN_FIELD_W-1:0] secondary_bin;
  } out_t;

  typedef struct packed {
    logic [7:0] grey_hue_limit;
    logic [7:0] black_value_limit;
    logic [7:0] white_value_limit;
  } cfg_t;

endpackage

>>> design/hht_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module hht_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 27
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/hht_classify.sv
// Maps one pixel to its histogram bin code.
module hht_classify
  import hht_pkg::*;
#(
  parameter int HUE_BINS = 24
) (
  input  logic [7:0]                       hue,
  input  logic [7:0]                       brightness,
  input  cfg_t                             cfg,
  output logic [$clog2(HUE_BINS+3)-1:0]    code
);

  localparam int TOTAL_BINS  = HUE_BINS + 3;
  localparam int CODE_W      = $clog2(TOTAL_BINS);
  localparam int RECIP_SHIFT = 23;
  // Rounded-up reciprocal of the hue span; exact for all products below 2^15.
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + HUE_SPAN - 1) / HUE_SPAN;
  localparam int SCALE       = HUE_BINS * RECIP;
  localparam int PROD_W      = 8 + $clog2(SCALE + 1);
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [CODE_W-1:0] hue_code;

  assign prod = PROD_W'(hue) * PROD_W'(SCALE);
  assign quot = prod[PROD_W-1:RECIP_SHIFT];

  // Hues past the nominal span land in the top hue bin.
  assign hue_code = (quot > QUOT_W'(HUE_BINS - 1)) ? CODE_W'(HUE_BINS - 1) : CODE_W'(quot);

  always_comb begin
    if (hue < cfg.grey_hue_limit) begin
      if (brightness < cfg.black_value_limit) begin
        code = CODE_W'(HUE_BINS + 2);
      end else if (brightness > cfg.white_value_limit) begin
        code = CODE_W'(HUE_BINS);
      end else begin
        code = CODE_W'(HUE_BINS + 1);
      end
    end else begin
      code = hue_code;
    end
  end

endmodule

>>> design/hht_scan.sv
// Sequencer that clears the counter RAM and scans it for the two largest bins.
module hht_scan
  import hht_pkg::*;
#(
  parameter int HUE_BINS   = 24,
  parameter int COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [COUNT_BITS-1:0]             rd_data,
  output logic                              rd_en,
  output logic [$clog2(HUE_BINS+3)-1:0]     rd_addr,
  output logic                              wr_en,
  output logic [$clog2(HUE_BINS+3)-1:0]     wr_addr,
  output logic                              done,
  output out_t                              result
);

  localparam int TOTAL_BINS = HUE_BINS + 3;
  localparam int CODE_W     = $clog2(TOTAL_BINS);
  localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(TOTAL_BINS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_WAIT, S_SCAN, S_DRAIN} state_t;

  state_t                state;
  logic [CODE_W-1:0]     idx;
  logic                  data_valid;
  logic [CODE_W-1:0]     data_idx;
  logic [CODE_W-1:0]     top_idx;
  logic [COUNT_BITS-1:0] top_cnt;
  logic [CODE_W-1:0]     sec_idx;
  logic [COUNT_BITS-1:0] sec_cnt;
  logic                  have_sec;
  logic [CODE_W-1:0]     top_idx_next;
  logic [COUNT_BITS-1:0] top_cnt_next;
  logic [CODE_W-1:0]     sec_idx_next;
  logic [COUNT_BITS-1:0] sec_cnt_next;
  logic                  have_sec_next;

  assign busy    = (state != S_IDLE);
  assign rd_en   = (state == S_SCAN);
  assign rd_addr = idx;
  assign wr_en   = (state == S_CLEAR) || data_valid;
  assign wr_addr = (state == S_CLEAR) ? idx : data_idx;

  // Running top two in ascending index order; strict compares keep the lowest index on ties.
  always_comb begin
    top_idx_next  = top_idx;
    top_cnt_next  = top_cnt;
    sec_idx_next  = sec_idx;
    sec_cnt_next  = sec_cnt;
    have_sec_next = have_sec;
    if (data_idx == '0) begin
      top_idx_next  = data_idx;
      top_cnt_next  = rd_data;
      have_sec_next = 1'b0;
    end else if (rd_data > top_cnt) begin
      sec_idx_next  = top_idx;
      sec_cnt_next  = top_cnt;
      top_idx_next  = data_idx;
      top_cnt_next  = rd_data;
      have_sec_next = 1'b1;
    end else if (!have_sec || (rd_data > sec_cnt)) begin
      sec_idx_next  = data_idx;
      sec_cnt_next  = rd_data;
      have_sec_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      data_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= (state == S_DRAIN);
      data_valid <= (state == S_SCAN);
      data_idx   <= idx;
      if (data_valid) begin
        top_idx  <= top_idx_next;
        top_cnt  <= top_cnt_next;
        sec_idx  <= sec_idx_next;
        sec_cnt  <= sec_cnt_next;
        have_sec <= have_sec_next;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_CODE) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_WAIT;
          end
        end
        // Lets the last pixel's count reach the RAM before the scan reads it.
        S_WAIT: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (idx == LAST_CODE) begin
            idx   <= '0;
            state <= S_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DRAIN: begin
          result.primary_bin   <= BIN_FIELD_W'(top_idx_next);
          result.secondary_bin <= BIN_FIELD_W'(sec_idx_next);
          state                <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/hue_histogram_top_two_unit.sv
// Top level of the hue histogram block: pixel counting pipeline and configuration registers.
//
// Pixels enter on pixel when start is high and busy is low, one per cycle.
// A pixel with inside_region set is counted into one of HUE_BINS + 3
// saturating counters held in a RAM. Counting is a read-modify-write through
// the registered RAM read and stage s1; a count written in one cycle is
// forwarded to a pixel of the same bin read in that same cycle, so pixels may
// follow back to back. A pixel with last_pixel set ends the region: busy rises
// while the scanner reads every counter once (one RAM read per cycle), keeps
// the two largest and writes each counter back to zero. done is high for one
// cycle with primary_bin and secondary_bin on result once the scanner has
// passed its wait, scan and drain states, and in that cycle busy is already
// low. The receiver cannot stall; a result is shown once. After reset busy
// stays high while the RAM is cleared; configuration writes are taken at all
// times on the APB port (grey hue limit at 0x0, black value limit at 0x4,
// white value limit at 0x8).
module hue_histogram_top_two_unit
  import hht_pkg::*;
#(
  parameter int HUE_BINS   = 24,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         pixel,
  output logic        done,
  output out_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TOTAL_BINS = HUE_BINS + 3;
  localparam int CODE_W     = $clog2(TOTAL_BINS);

  cfg_t                  cfg;
  logic                  reg_write;
  logic                  accept;
  logic [CODE_W-1:0]     pix_code;
  logic                  s1_valid;
  logic [CODE_W-1:0]     s1_code;
  logic                  wb_valid;
  logic [CODE_W-1:0]     wb_code;
  logic [COUNT_BITS-1:0] wb_count;
  logic [COUNT_BITS-1:0] count_cur;
  logic [COUNT_BITS-1:0] count_next;
  logic                  ram_rd_en;
  logic [CODE_W-1:0]     ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_rd_data;
  logic                  ram_wr_en;
  logic [CODE_W-1:0]     ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;
  logic                  scan_rd_en;
  logic [CODE_W-1:0]     scan_rd_addr;
  logic                  scan_wr_en;
  logic [CODE_W-1:0]     scan_wr_addr;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grey_hue_limit    <= GREY_HUE_RESET;
      cfg.black_value_limit <= BLACK_VALUE_RESET;
      cfg.white_value_limit <= WHITE_VALUE_RESET;
    end else if (reg_write) begin
      unique case (paddr[3:2])
        REG_GREY_HUE:    cfg.grey_hue_limit    <= pwdata[7:0];
        REG_BLACK_VALUE: cfg.black_value_limit <= pwdata[7:0];
        REG_WHITE_VALUE: cfg.white_value_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GREY_HUE:    prdata = 32'(cfg.grey_hue_limit);
      REG_BLACK_VALUE: prdata = 32'(cfg.black_value_limit);
      REG_WHITE_VALUE: prdata = 32'(cfg.white_value_limit);
      default:         prdata = '0;
    endcase
  end

  // Pixel counting.
  assign accept = start && !busy;

  hht_classify #(
    .HUE_BINS(HUE_BINS)
  ) u_classify (
    .hue        (pixel.hue),
    .brightness (pixel.brightness),
    .cfg        (cfg),
    .code       (pix_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      s1_valid <= accept && pixel.inside_region;
      wb_valid <= s1_valid;
    end
    s1_code  <= pix_code;
    wb_code  <= s1_code;
    wb_count <= count_next;
  end

  // The RAM read was taken at the same edge as the previous write; bypass it on a match.
  assign count_cur  = (wb_valid && (wb_code == s1_code)) ? wb_count : ram_rd_data;
  assign count_next = (count_cur == '1) ? count_cur : count_cur + 1'b1;

  assign ram_rd_en   = busy ? scan_rd_en : accept;
  assign ram_rd_addr = busy ? scan_rd_addr : pix_code;
  assign ram_wr_en   = s1_valid || scan_wr_en;
  assign ram_wr_addr = s1_valid ? s1_code : scan_wr_addr;
  assign ram_wr_data = s1_valid ? count_next : '0;

  hht_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(TOTAL_BINS)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  hht_scan #(
    .HUE_BINS  (HUE_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && pixel.last_pixel),
    .busy    (busy),
    .rd_data (ram_rd_data),
    .rd_en   (scan_rd_en),
    .rd_addr (scan_rd_addr),
    .wr_en   (scan_wr_en),
    .wr_addr (scan_wr_addr),
    .done    (done),
    .result  (result)
  );

  // The counting write and the scanner's clearing write never compete for the port.
  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && scan_wr_en))
    else $error("counting write and scan write in the same cycle");

  // The last pixel of a region always starts a scan.
  a_last_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && pixel.last_pixel) |=> busy)
    else $error("last pixel did not start a scan");

  // A result only follows a scan.
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding scan");

  // No pixel is counted while the scanner owns the RAM.
  a_no_count_when_busy: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !scan_rd_en)
    else $error("pixel counted during a scan");

endmodule

>>> test/tb.sv
// Self-checking testbench for the hue histogram top-two block.
module tb;
  import hht_pkg::*;

  localparam int HUE_BINS   = 24;
  localparam int COUNT_BITS = 20;
  localparam int TOTAL_BINS = HUE_BINS + 3;
  localparam int WHITE_BIN  = HUE_BINS;
  localparam int GREY_BIN   = HUE_BINS + 1;
  localparam int BLACK_BIN  = HUE_BINS + 2;
  localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;
  localparam int SCAN_CYCLES = HUE_BINS + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Tracks the region histogram and the bin pairs still owed by the block.
  class dominant_bin_scoreboard;
    longint bin_count[TOTAL_BINS];
    cfg_t   limits;
    out_t   pending_pairs[$];
    int     errors;
    int     pixels_seen;
    int     regions_checked;

    function new();
      foreach (bin_count[i]) bin_count[i] = 0;
      limits.grey_hue_limit    = GREY_HUE_RESET;
      limits.black_value_limit = BLACK_VALUE_RESET;
      limits.white_value_limit = WHITE_VALUE_RESET;
      errors = 0;
      pixels_seen = 0;
      regions_checked = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_GREY_HUE:    limits.grey_hue_limit    = data[7:0];
        REG_BLACK_VALUE: limits.black_value_limit = data[7:0];
        REG_WHITE_VALUE: limits.white_value_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(in_t px);
      int   code;
      int   top;
      int   second;
      bit   have_second;
      out_t pair;
      pixels_seen++;
      if (px.inside_region) begin
        if (px.hue < limits.grey_hue_limit) begin
          if (px.brightness < limits.black_value_limit) code = BLACK_BIN;
          else if (px.brightness > limits.white_value_limit) code = WHITE_BIN;
          else code = GREY_BIN;
        end else begin
          code = (int'(px.hue) * HUE_BINS) / HUE_SPAN;
          if (code > HUE_BINS - 1) code = HUE_BINS - 1;
        end
        if (bin_count[code] < COUNT_MAX) bin_count[code]++;
      end
      if (!px.last_pixel) return;
      top = 0;
      for (int i = 1; i < TOTAL_BINS; i++)
        if (bin_count[i] > bin_count[top]) top = i;
      second = 0;
      have_second = 0;
      for (int i = 0; i < TOTAL_BINS; i++) begin
        if (i != top && (!have_second || bin_count[i] > bin_count[second])) begin
          second = i;
          have_second = 1;
        end
      end
      pair.primary_bin   = BIN_FIELD_W'(top);
      pair.secondary_bin = BIN_FIELD_W'(second);
      pending_pairs = {pending_pairs, pair};
      foreach (bin_count[i]) bin_count[i] = 0;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual primary %0d secondary %0d",
                 $time, got.primary_bin, got.secondary_bin);
        errors++;
        return;
      end
      want = pending_pairs.pop_front();
      regions_checked++;
      if (got.primary_bin !== want.primary_bin) begin
        $display("%0t: primary_bin mismatch, expected %0d actual %0d",
                 $time, want.primary_bin, got.primary_bin);
        errors++;
      end
      if (got.secondary_bin !== want.secondary_bin) begin
        $display("%0t: secondary_bin mismatch, expected %0d actual %0d",
                 $time, want.secondary_bin, got.secondary_bin);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_t         pixel = '0;
  logic        done;
  out_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dominant_bin_scoreboard sb;
  int idle_pct;
  int settings_used;
  int cycle_count = 0;

  hue_histogram_top_two_unit #(
    .HUE_BINS  (HUE_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending_pairs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Pixel and result transfers are both observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_pixel(pixel);
    end
  end

  function automatic in_t make_pixel(logic [7:0] hue, logic [7:0] bright,
                                     logic in_region, logic last);
    in_t px;
    px.hue = hue;
    px.brightness = bright;
    px.inside_region = in_region;
    px.last_pixel = last;
    return px;
  endfunction

  task automatic send_pixel(input in_t px);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] word;
    word = $urandom();
    word[7:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(idx, word);
  endtask

  task automatic apb_read_check(input logic [1:0] idx, input logic [7:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, want}) begin
      $display("%0t: register %0d readback mismatch, expected %0h actual %0h",
               $time, idx, {24'd0, want}, prdata);
      sb.errors++;
    end
  endtask

  // Waits for every owed result, then lets the scan and counting pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (sb.pending_pairs.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] grey, input logic [7:0] black,
                            input logic [7:0] white);
    drain();
    apb_write(REG_GREY_HUE, grey);
    apb_write(REG_BLACK_VALUE, black);
    apb_write(REG_WHITE_VALUE, white);
    apb_write(REG_UNUSED, 8'($urandom()));
    apb_read_check(REG_GREY_HUE, sb.limits.grey_hue_limit);
    apb_read_check(REG_BLACK_VALUE, sb.limits.black_value_limit);
    apb_read_check(REG_WHITE_VALUE, sb.limits.white_value_limit);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  // A region favors a few hues so that the top two bins are meaningful;
  // some pixels are noise with random fields, including stray region ends.
  task automatic send_region(inout int sent);
    int         len;
    int         pick;
    logic [7:0] fav[3];
    in_t        px;
    pick = $urandom_range(99);
    if (pick < 5) len = 1;
    else if (pick < 90) len = $urandom_range(2, 20);
    else len = $urandom_range(21, 80);
    foreach (fav[k]) begin
      pick = $urandom_range(99);
      if (pick < 25) fav[k] = 8'($urandom_range(0, 4));
      else if (pick < 90) fav[k] = 8'($urandom_range(0, 179));
      else fav[k] = 8'($urandom_range(180, 255));
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 80) begin
        px = make_pixel(fav[$urandom_range(0, 2)], 8'($urandom()), 1'b1, i == len - 1);
      end else begin
        px = make_pixel(8'($urandom()), 8'($urandom()), 1'($urandom()),
                        (i == len - 1) || ($urandom_range(99) == 0));
      end
      send_pixel(px);
      sent++;
    end
  endtask

  task automatic random_phase(input int pct, input int count);
    int sent;
    sent = 0;
    idle_pct = pct;
    while (sent < count) send_region(sent);
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    settings_used = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty region, then every class at the reset thresholds.
    send_pixel(make_pixel(8'd90, 8'd90, 1'b0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd255, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd50, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd200, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd49, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd201, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd2, 8'd10, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd7, 8'd128, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd8, 8'd128, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd179, 8'd255, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd180, 8'd0, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd100, 8'd100, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd179, 8'd1, 1'b1, 1'b1));
    // Two-bin tie: the lower index must win.
    send_pixel(make_pixel(8'd60, 8'd100, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd30, 8'd100, 1'b1, 1'b1));

    // Black and white thresholds overlap: black must win.
    set_limits(8'd179, 8'd255, 8'd0);
    send_pixel(make_pixel(8'd100, 8'd100, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd178, 8'd254, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd179, 8'd255, 1'b1, 1'b1));
    random_phase(87, 130);

    set_limits(8'd0, 8'd0, 8'd255);
    send_pixel(make_pixel(8'd0, 8'd0, 1'b1, 1'b1));
    random_phase(0, 130);

    set_limits(8'd30, 8'd80, 8'd170);
    random_phase(8, 130);

    set_limits(GREY_HUE_RESET, BLACK_VALUE_RESET, WHITE_VALUE_RESET);
    random_phase(87, 120);

    set_limits(8'($urandom_range(0, 179)), 8'($urandom()), 8'($urandom()));
    random_phase(0, 70);

    set_limits(8'($urandom_range(0, 179)), 8'($urandom()), 8'($urandom()));
    random_phase($urandom_range(0, 50), 70);

    drain();
    if (sb.pending_pairs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_pairs.size());
      sb.errors++;
    end
    $display("Run covered %0d pixels and %0d finished regions under %0d threshold settings.",
             sb.pixels_seen, sb.regions_checked, settings_used);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
